>>> rtl/rau_pkg.sv
`default_nettype none

package rau_pkg;

  localparam int NUM_WIDTH_DEF = 16;

  typedef enum logic [2:0] {
    OP_REDUCE = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVER = 2'd2
  } status_t;

endpackage

`default_nettype wire

>>> rtl/rau_gcd.sv
`default_nettype none

module rau_gcd #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] u_in,
  input  wire logic [WIDTH-1:0] v_in,
  output logic                  done,
  output logic [WIDTH-1:0]      g
);

  localparam int KW = $clog2(WIDTH + 1);

  typedef enum logic [1:0] {
    G_IDLE,
    G_RUN,
    G_SHIFT
  } gstate_t;

  gstate_t           state;
  logic [WIDTH-1:0]  u;
  logic [WIDTH-1:0]  v;
  logic [KW-1:0]     k;

  assign g = u;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= G_IDLE;
    end else begin
      case (state)
        G_IDLE: begin
          if (start) begin
            u     <= u_in;
            v     <= v_in;
            k     <= '0;
            state <= G_RUN;
          end
        end
        G_RUN: begin
          if (u == '0 || v == '0) begin
            u     <= u | v;
            state <= G_SHIFT;
          end else if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + KW'(1);
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u >= v) begin
            u <= u - v;
          end else begin
            v <= v - u;
          end
        end
        G_SHIFT: begin
          // restore the common power of two
          if (k == '0) begin
            done  <= 1'b1;
            state <= G_IDLE;
          end else begin
            u <= u << 1;
            k <= k - KW'(1);
          end
        end
        default: begin
          state <= G_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/rau_div.sv
`default_nettype none

module rau_div #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [WIDTH-1:0] divisor,
  output logic                  done,
  output logic [WIDTH-1:0]      quotient
);

  localparam int CW = $clog2(WIDTH + 1);

  typedef enum logic {
    D_IDLE,
    D_RUN
  } dstate_t;

  dstate_t           state;
  logic [WIDTH-1:0]  r;
  logic [WIDTH-1:0]  q;
  logic [WIDTH-1:0]  d;
  logic [CW-1:0]     cnt;
  logic [WIDTH+1:0]  diff;
  logic              borrow;

  // restoring division, one quotient bit per cycle
  assign diff     = {1'b0, r, q[WIDTH-1]} - {2'b00, d};
  assign borrow   = diff[WIDTH+1];
  assign quotient = q;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= D_IDLE;
    end else begin
      case (state)
        D_IDLE: begin
          if (start) begin
            r     <= '0;
            q     <= dividend;
            d     <= divisor;
            cnt   <= CW'(WIDTH);
            state <= D_RUN;
          end
        end
        D_RUN: begin
          if (borrow) begin
            r <= {r[WIDTH-2:0], q[WIDTH-1]};
          end else begin
            r <= diff[WIDTH-1:0];
          end
          q   <= {q[WIDTH-2:0], ~borrow};
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/rational_arithmetic_unit.sv
// rational_arithmetic_unit
//
// exact arithmetic on two rationals (signed numerator over unsigned denominator)
// input channel: in_valid/in_ready with operation, a_num, a_den, b_num, b_den
// output channel: out_valid/out_ready with result_num, result_den, status
// every input transfer gives exactly one output transfer, in order
// status 0 ok, 1 divide by zero, 2 overflow; on error the result is 0/1
// one item at a time: in_ready is high only while no item is in work
// path from input transfer to out_valid: a zero denominator or zero divisor
//   goes straight from the check to the result, a zero numerator ends after
//   the multiply and sum, otherwise multiply and sum on one shared multiplier,
//   a binary gcd of shift/subtract steps, then two bit-serial divisions
//   of numerator and denominator by the gcd
// the unit returns to idle when the result is loaded; the next input
//   transfer can follow in the cycle after
// the result sits in an output register; the next item is accepted while
//   it waits, and a finished item waits in place if that register is full
// reset (rst, synchronous) empties the unit and drops any pending result
`default_nettype none

module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [2:0]                  operation,
  input  wire logic signed [NUM_WIDTH-1:0] a_num,
  input  wire logic [NUM_WIDTH-1:0]        a_den,
  input  wire logic signed [NUM_WIDTH-1:0] b_num,
  input  wire logic [NUM_WIDTH-1:0]        b_den,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [NUM_WIDTH-1:0]      result_num,
  output logic [NUM_WIDTH-1:0]             result_den,
  output logic [1:0]                       status
);

  localparam int W  = NUM_WIDTH;
  localparam int MW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int PW = 2 * W + 2;

  localparam logic [MW-1:0] POS_MAX = MW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [MW-1:0] NEG_MAX = MW'(64'd1 << (W - 1));
  localparam logic [MW-1:0] DEN_MAX = MW'((64'd1 << W) - 64'd1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_SUM,
    S_ABS,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_RANGE,
    S_FINISH
  } state_t;

  state_t              state;
  op_t                 op;
  logic signed [W-1:0] an;
  logic [W-1:0]        ad;
  logic signed [W-1:0] bn;
  logic [W-1:0]        bd;

  logic signed [SW-1:0] p1;
  logic signed [SW-1:0] p2;
  logic signed [SW-1:0] n;
  logic [MW-1:0]        den;
  logic [MW-1:0]        m;
  logic                 neg;
  logic [MW-1:0]        g;
  logic [MW-1:0]        mq;

  logic signed [W-1:0] fin_num;
  logic [W-1:0]        fin_den;
  status_t             fin_status;
  status_t             status_r;

  logic signed [W:0]    an_ext;
  logic signed [W:0]    bn_ext;
  logic signed [W:0]    ad_ext;
  logic signed [W:0]    bd_ext;
  logic signed [W:0]    bn_abs;
  logic                 bn_neg;
  logic signed [W:0]    mul_a;
  logic signed [W:0]    mul_b;
  logic signed [PW-1:0] prod;
  logic [MW-1:0]        m_abs;
  logic [W-1:0]         mq_low;

  logic          gcd_start;
  logic          gcd_done;
  logic [MW-1:0] gcd_g;
  logic          div_start;
  logic          div_done;
  logic [MW-1:0] div_dividend;
  logic [MW-1:0] div_quot;

  assign in_ready = (state == S_IDLE);
  assign status   = status_r;

  assign an_ext = {an[W-1], an};
  assign bn_ext = {bn[W-1], bn};
  assign ad_ext = {1'b0, ad};
  assign bd_ext = {1'b0, bd};
  assign bn_neg = bn[W-1];
  assign bn_abs = bn_neg ? -bn_ext : bn_ext;

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL1: begin
        mul_a = (op == OP_DIV && bn_neg) ? -an_ext : an_ext;
        case (op)
          OP_MUL:    mul_b = bn_ext;
          OP_REDUCE: mul_b = (W + 1)'(1);
          default:   mul_b = bd_ext;
        endcase
      end
      S_MUL2: begin
        if (op == OP_ADD || op == OP_SUB) begin
          mul_a = bn_ext;
          mul_b = ad_ext;
        end
      end
      S_MUL3: begin
        mul_a = ad_ext;
        case (op)
          OP_REDUCE: mul_b = (W + 1)'(1);
          OP_DIV:    mul_b = bn_abs;
          default:   mul_b = bd_ext;
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod         = mul_a * mul_b;
  assign m_abs        = n[SW-1] ? MW'(-n) : n[MW-1:0];
  assign div_dividend = (state == S_DIVN) ? m : den;
  assign mq_low       = mq[W-1:0];

  rau_gcd #(
    .WIDTH (MW)
  ) u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (gcd_start),
    .u_in  (m),
    .v_in  (den),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  rau_div #(
    .WIDTH (MW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (g),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    gcd_start <= 1'b0;
    div_start <= 1'b0;
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (operation > 3'(OP_DIV)) begin
              op <= OP_REDUCE;
            end else begin
              op <= op_t'(operation);
            end
            an    <= a_num;
            ad    <= a_den;
            bn    <= b_num;
            bd    <= b_den;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (ad == '0 || (op != OP_REDUCE && bd == '0) || (op == OP_DIV && bn == '0)) begin
            fin_num    <= '0;
            fin_den    <= W'(1);
            fin_status <= ST_DIV0;
            state      <= S_FINISH;
          end else begin
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          p1    <= prod[SW-1:0];
          state <= S_MUL2;
        end
        S_MUL2: begin
          p2    <= prod[SW-1:0];
          state <= S_MUL3;
        end
        S_MUL3: begin
          den   <= prod[MW-1:0];
          state <= S_SUM;
        end
        S_SUM: begin
          n     <= (op == OP_ADD) ? p1 + p2 : p1 - p2;
          state <= S_ABS;
        end
        S_ABS: begin
          neg <= n[SW-1];
          m   <= m_abs;
          if (m_abs == '0) begin
            // zero numerator reduces to 0/1
            fin_num    <= '0;
            fin_den    <= W'(1);
            fin_status <= ST_OK;
            state      <= S_FINISH;
          end else begin
            gcd_start <= 1'b1;
            state     <= S_GCD;
          end
        end
        S_GCD: begin
          if (gcd_done) begin
            g         <= gcd_g;
            div_start <= 1'b1;
            state     <= S_DIVN;
          end
        end
        S_DIVN: begin
          if (div_done) begin
            mq        <= div_quot;
            div_start <= 1'b1;
            state     <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (div_done) begin
            den   <= div_quot;
            state <= S_RANGE;
          end
        end
        S_RANGE: begin
          if ((neg && mq > NEG_MAX) || (!neg && mq > POS_MAX) || den > DEN_MAX) begin
            fin_num    <= '0;
            fin_den    <= W'(1);
            fin_status <= ST_OVER;
          end else begin
            fin_num    <= neg ? -mq_low : mq_low;
            fin_den    <= den[W-1:0];
            fin_status <= ST_OK;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            result_num <= fin_num;
            result_den <= fin_den;
            status_r   <= fin_status;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import rau_pkg::*;

  localparam int NW = NUM_WIDTH_DEF;
  localparam logic signed [NW-1:0] NUM_MAX = NW'(2 ** (NW - 1) - 1);
  localparam logic signed [NW-1:0] NUM_MIN = NW'(-(2 ** (NW - 1)));
  localparam logic [NW-1:0] DEN_MAX = NW'(2 ** NW - 1);
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;
  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLD_CYCLES = 1000;
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [NW-1:0] num;
    logic [NW-1:0]        den;
    logic [1:0]           st;
  } result_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           operation = '0;
  logic signed [NW-1:0] a_num = '0;
  logic [NW-1:0]        a_den = '0;
  logic signed [NW-1:0] b_num = '0;
  logic [NW-1:0]        b_den = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [NW-1:0] result_num;
  logic [NW-1:0]        result_den;
  logic [1:0]           status;

  result_t pending_results[$];
  int      mismatches = 0;
  int      cycles = 0;
  int      hold_req = 0;
  int      hold_seen = 0;
  int      hold_left = 0;
  int      run_left = 0;
  logic    stall_run = 1'b0;

  rational_arithmetic_unit #(.NUM_WIDTH(NW)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .a_num     (a_num),
    .a_den     (a_den),
    .b_num     (b_num),
    .b_den     (b_den),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result_num(result_num),
    .result_den(result_den),
    .status    (status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic result_t rational_result(logic [2:0] op, logic signed [NW-1:0] an,
                                              logic [NW-1:0] ad, logic signed [NW-1:0] bn,
                                              logic [NW-1:0] bd);
    result_t res;
    op_t     opc;
    longint  n, m, d, x, y, r;
    logic    neg;
    res.num = '0;
    res.den = NW'(1);
    res.st  = ST_DIV0;
    opc = (op > 3'(OP_DIV)) ? OP_REDUCE : op_t'(op);
    if (ad == 0 || (opc != OP_REDUCE && bd == 0)) return res;
    d = longint'(ad) * longint'(bd);
    case (opc)
      OP_ADD: n = longint'(an) * longint'(bd) + longint'(bn) * longint'(ad);
      OP_SUB: n = longint'(an) * longint'(bd) - longint'(bn) * longint'(ad);
      OP_MUL: n = longint'(an) * longint'(bn);
      OP_DIV: begin
        if (bn == 0) return res;
        n = longint'(an) * longint'(bd);
        if (bn < 0) n = -n;
        d = longint'(ad) * (bn < 0 ? -longint'(bn) : longint'(bn));
      end
      default: begin
        n = longint'(an);
        d = longint'(ad);
      end
    endcase
    neg = n < 0;
    m = neg ? -n : n;
    // euclid on magnitude and denominator
    x = m;
    y = d;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    m = m / x;
    d = d / x;
    res.st = ST_OVER;
    if (neg ? (m > -longint'(NUM_MIN)) : (m > longint'(NUM_MAX))) return res;
    if (d > longint'(DEN_MAX)) return res;
    res.num = NW'(neg ? -m : m);
    res.den = NW'(d);
    res.st  = ST_OK;
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %0d/%0d status %0d", $time, result_num, result_den,
                 status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (result_num !== want.num) begin
          $display("%0t: result_num expected %0d actual %0d", $time, want.num, result_num);
          mismatches++;
        end
        if (result_den !== want.den) begin
          $display("%0t: result_den expected %0d actual %0d", $time, want.den, result_den);
          mismatches++;
        end
        if (status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          mismatches++;
        end
      end
    end
  end

  // receiver stall pattern and long hold-off
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (run_left == 0) begin
        stall_run = ($urandom_range(0, 2) == 0);
        if (stall_run) run_left = $urandom_range(1, 16);
        else if ($urandom_range(0, 7) == 0) run_left = $urandom_range(100, 300);
        else run_left = $urandom_range(1, 30);
      end
      run_left--;
      out_ready <= !stall_run;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(logic [2:0] op, logic signed [NW-1:0] an, logic [NW-1:0] ad,
                           logic signed [NW-1:0] bn, logic [NW-1:0] bd);
    in_valid  <= 1'b1;
    operation <= op;
    a_num     <= an;
    a_den     <= ad;
    b_num     <= bn;
    b_den     <= bd;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    pending_results.push_back(rational_result(op, an, ad, bn, bd));
  endtask

  task automatic pause_sender(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_for_results(int settle);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic signed [NW-1:0] random_num();
    case ($urandom_range(0, 9))
      0, 1, 2: return NW'($urandom);
      3, 4, 5, 6: return NW'($urandom_range(0, 128) - 64);
      7: begin
        case ($urandom_range(0, 4))
          0: return NUM_MIN;
          1: return NUM_MAX;
          2: return -1;
          3: return 0;
          default: return 1;
        endcase
      end
      default: return NW'(($urandom_range(0, 400) - 200) * 6);
    endcase
  endfunction

  function automatic logic [NW-1:0] random_den();
    int pick;
    pick = $urandom_range(0, 39);
    if (pick == 0) return 0;
    if (pick <= 12) return NW'($urandom);
    if (pick <= 30) return NW'($urandom_range(1, 64));
    if (pick == 31) return 1;
    if (pick == 32) return DEN_MAX;
    if (pick == 33) return NW'(2 ** (NW - 1));
    return NW'($urandom_range(1, 400) * 6);
  endfunction

  task automatic send_random_item();
    logic [2:0] op;
    if ($urandom_range(0, 19) < 2) op = 3'($urandom_range(5, 7));
    else op = 3'($urandom_range(0, 4));
    send_item(op, random_num(), random_den(), random_num(), random_den());
  endtask

  task automatic test_zero_denominators();
    send_item(OP_REDUCE, 5, 0, 3, 4);
    send_item(OP_ADD, 7, 0, 1, 2);
    send_item(OP_MUL, 3, 5, 9, 0);
    send_item(OP_REDUCE, -9, 6, 1, 0);
  endtask

  task automatic test_divide_by_zero_value();
    send_item(OP_DIV, 3, 4, 0, 7);
    send_item(OP_DIV, 0, 1, 0, DEN_MAX);
  endtask

  task automatic test_negative_divisor();
    send_item(OP_DIV, 3, 4, -5, 7);
    send_item(OP_DIV, NUM_MIN, 1, -1, 1);
    send_item(OP_DIV, -3, 1, NUM_MIN, DEN_MAX);
  endtask

  task automatic test_zero_result();
    send_item(OP_REDUCE, 0, DEN_MAX, 0, 0);
    send_item(OP_SUB, 5, 7, 5, 7);
    send_item(OP_MUL, 0, 3, NUM_MIN, 9);
  endtask

  task automatic test_overflow();
    send_item(OP_ADD, NUM_MAX, 1, 1, 1);
    send_item(OP_MUL, NUM_MIN, 1, -1, 1);
    send_item(OP_MUL, 1, DEN_MAX, 1, 2);
    send_item(OP_REDUCE, NUM_MIN, 1, 0, 0);
    send_item(OP_REDUCE, NUM_MAX, DEN_MAX, 0, 0);
  endtask

  task automatic test_field_extremes();
    send_item(OP_SPARE_A, 12, 18, NUM_MIN, 0);
    send_item(OP_SPARE_B, -1, DEN_MAX, NUM_MAX, DEN_MAX);
    send_item(OP_SPARE_C, NUM_MIN, 2, -1, 0);
    send_item(OP_SUB, NUM_MIN, DEN_MAX, NUM_MAX, DEN_MAX);
    send_item(OP_DIV, -1, DEN_MAX, -1, DEN_MAX);
    wait_for_results(0);
  endtask

  task automatic test_output_backpressure();
    hold_req++;
    repeat (8) send_random_item();
    wait_for_results(0);
  endtask

  task automatic test_random_traffic();
    int sent;
    int burst;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) send_random_item();
      sent += burst;
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 15));
      if ($urandom_range(0, 19) == 0) wait_for_results(0);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_zero_denominators();
    test_divide_by_zero_value();
    test_negative_divisor();
    test_zero_result();
    test_overflow();
    test_field_extremes();
    test_output_backpressure();
    test_random_traffic();
    wait_for_results(SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
